/* rtl/core/wmf_pkg.sv */
// package for the window mode finder: field widths, register indexes,
// reset values and the command word passed from front to back
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wmf_pkg;

  // payload and register widths
  localparam int VAL_W     = 8;
  localparam int POS_W     = 16;
  localparam int CNT_W     = POS_W + 1;
  localparam int CFG_W     = 16;
  localparam int MAXV_W    = 8;
  localparam int CFG_IDX_W = 2;

  // default number of value bins
  localparam int DEF_VALUE_BINS = 256;

  // command queue depth, power of two
  localparam int QUEUE_DEPTH = 4;

  // saturation point of a bin count
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register reset values
  localparam logic [POS_W-1:0]  WIN_START_RST = '0;
  localparam logic [POS_W-1:0]  WIN_END_RST   = {POS_W{1'b1}};
  localparam logic [MAXV_W-1:0] MAX_VALUE_RST = {MAXV_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START = 2'd0,
    CFG_WINDOW_END   = 2'd1,
    CFG_MAX_VALUE    = 2'd2
  } cfg_idx_t;

  // classified request from the front to the back
  typedef struct packed {
    logic [VAL_W-1:0] bin;
    logic [POS_W-1:0] pos;
    logic             count_en;
    logic             last;
  } wmf_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/wmf_if.sv */
// channel interfaces of the window mode finder: sample input and result output
// depends on wmf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface wmf_in_if;
  logic                      valid;
  logic                      ready;
  logic [wmf_pkg::VAL_W-1:0] sample_value;
  logic                      last_sample;

  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface wmf_out_if;
  logic                      valid;
  logic                      ready;
  logic [wmf_pkg::VAL_W-1:0] mode_value;
  logic [wmf_pkg::CNT_W-1:0] mode_count;
  logic [wmf_pkg::POS_W-1:0] first_position;

  modport source (output valid, output mode_value, output mode_count,
                  output first_position, input ready);
  modport sink   (input valid, input mode_value, input mode_count,
                  input first_position, output ready);
endinterface

`default_nettype wire

/* rtl/core/window_mode_finder_top.sv */
// top level of the window mode finder: configuration registers and the
// front, queue and back parts; depends on wmf_pkg, wmf_if and the wmf_* modules
`timescale 1ns / 1ps
`default_nettype none

// Window mode finder. Samples are numbered from 0; those whose position lies
// in [window_start, window_end] and whose value is at most max_value are
// counted per value. On the sample marked last a single result is returned:
// the most frequent value (ties to the larger value), its count and the
// position where it first appeared (0 when nothing was counted); counts and
// numbering then restart. Samples are taken at one per cycle unless the queue is
// full or the count memory is being cleared: each one is a read-modify-write of
// the count memory with forwarding, behind a four-entry command queue. The last
// sample triggers a sweep over all VALUE_BINS entries of the count memory
// through its single read port before the result is registered; the queue
// keeps taking samples meanwhile until it fills. After reset the count memory
// is cleared in a pass over all VALUE_BINS entries with in_ch.ready low.
// Registers may be written only while no frame is in progress.
module window_mode_finder_top #(
  parameter int VALUE_BINS = wmf_pkg::DEF_VALUE_BINS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  wmf_in_if.sink                             in_ch,
  wmf_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [wmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wmf_pkg::CFG_W-1:0]     cfg_wdata
);
  import wmf_pkg::*;

  logic [POS_W-1:0]  window_start_r;
  logic [POS_W-1:0]  window_end_r;
  logic [MAXV_W-1:0] max_value_r;
  logic              clear_busy;
  logic              q_ready;
  logic              q_push;
  wmf_cmd_t          q_data;
  logic              q_valid;
  logic              q_pop;
  wmf_cmd_t          q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_start_r <= WIN_START_RST;
      window_end_r   <= WIN_END_RST;
      max_value_r    <= MAX_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_START: window_start_r <= POS_W'(cfg_wdata);
        CFG_WINDOW_END:   window_end_r   <= POS_W'(cfg_wdata);
        CFG_MAX_VALUE:    max_value_r    <= MAXV_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  wmf_front #(.VALUE_BINS(VALUE_BINS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .window_start (window_start_r),
    .window_end   (window_end_r),
    .max_value    (max_value_r),
    .clear_busy   (clear_busy),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .q_push       (q_push)
  );

  wmf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .head       (q_head)
  );

  wmf_back #(.VALUE_BINS(VALUE_BINS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .max_value  (max_value_r),
    .clear_busy (clear_busy),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/core/wmf_front.sv */
// front part: accepts samples, numbers them and classifies each against
// the window and the value limit; depends on wmf_pkg and wmf_if
`timescale 1ns / 1ps
`default_nettype none

module wmf_front #(
  parameter int VALUE_BINS = wmf_pkg::DEF_VALUE_BINS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  wmf_in_if.sink                          in_ch,
  input  wire logic [wmf_pkg::POS_W-1:0]  window_start,
  input  wire logic [wmf_pkg::POS_W-1:0]  window_end,
  input  wire logic [wmf_pkg::MAXV_W-1:0] max_value,
  input  wire logic                       clear_busy,
  input  wire logic                       q_ready,
  output wmf_pkg::wmf_cmd_t               q_data,
  output logic                            q_push
);
  import wmf_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             in_window;
  logic             in_range;

  // no requests while the bin memory is being cleared
  assign in_ch.ready = q_ready & ~clear_busy;
  assign q_push      = in_ch.valid & in_ch.ready;

  // classification
  assign in_window = (pos_r >= window_start) && (pos_r <= window_end);
  assign in_range  = (in_ch.sample_value <= max_value) &&
                     (32'(in_ch.sample_value) < VALUE_BINS);

  always_comb begin
    q_data.bin      = in_ch.sample_value;
    q_data.pos      = pos_r;
    q_data.count_en = in_window & in_range;
    q_data.last     = in_ch.last_sample;
  end

  // position counter, restarts after the last sample
  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = in_ch.last_sample ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wmf_queue.sv */
// short command queue between the front and the back parts
// depends on wmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module wmf_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire wmf_pkg::wmf_cmd_t  push_data,
  output logic                    push_ready,
  input  wire logic               pop,
  output logic                    pop_valid,
  output wmf_pkg::wmf_cmd_t       head
);
  import wmf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  wmf_cmd_t         entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   fill_r, fill_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill_r != (PTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (PTR_W + 1)'(1);
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wmf_back.sv */
// back part: bin count and first position memories, count update with
// forwarding, and the result sweep that also clears the counts
// depends on wmf_pkg and wmf_if
`timescale 1ns / 1ps
`default_nettype none

module wmf_back #(
  parameter int VALUE_BINS = wmf_pkg::DEF_VALUE_BINS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire wmf_pkg::wmf_cmd_t          q_head,
  output logic                            q_pop,
  input  wire logic [wmf_pkg::MAXV_W-1:0] max_value,
  output logic                            clear_busy,
  wmf_out_if.source                       out_ch
);
  import wmf_pkg::*;

  localparam int BIN_W = (VALUE_BINS > 1) ? $clog2(VALUE_BINS) : 1;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(VALUE_BINS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } back_state_t;

  // memories
  logic [CNT_W-1:0] cnt_mem  [VALUE_BINS];
  logic [POS_W-1:0] fpos_mem [VALUE_BINS];
  logic [CNT_W-1:0] cnt_rd_r;
  logic [POS_W-1:0] fpos_rd_r;

  // control state
  back_state_t      state_r, state_nxt;
  logic [BIN_W-1:0] scan_addr_r, scan_addr_nxt;
  logic             s1_vld_r, s1_vld_nxt;
  logic             sc_vld_r, sc_vld_nxt;
  logic             fwd_vld_r, fwd_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload state
  wmf_cmd_t         s1_cmd_r;
  logic [BIN_W-1:0] sc_idx_r;
  logic [BIN_W-1:0] fwd_addr_r;
  logic [CNT_W-1:0] fwd_data_r;
  logic [VAL_W-1:0] best_val_r;
  logic [CNT_W-1:0] best_cnt_r;
  logic [POS_W-1:0] best_pos_r;
  logic [VAL_W-1:0] out_val_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [POS_W-1:0] out_pos_r;

  logic [BIN_W-1:0] rd_addr;
  logic [BIN_W-1:0] s1_addr;
  logic [CNT_W-1:0] s1_old;
  logic [CNT_W-1:0] s1_new;
  logic             item_wr;
  logic             cnt_we;
  logic [BIN_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic             fpos_we;
  logic             start_scan;
  logic             take;
  logic             emit;

  assign clear_busy = (state_r == ST_CLEAR);

  // count update: stale read data is replaced by the write of the previous cycle
  assign s1_addr = BIN_W'(s1_cmd_r.bin);
  assign s1_old  = (fwd_vld_r && (fwd_addr_r == s1_addr)) ? fwd_data_r : cnt_rd_r;
  assign s1_new  = (s1_old == CNT_MAX) ? s1_old : s1_old + CNT_W'(1);
  assign item_wr = (state_r == ST_RUN) && s1_vld_r && s1_cmd_r.count_en;
  assign fpos_we = item_wr && (s1_old == '0);

  // hold back new requests once the last one is in the update stage
  assign q_pop      = (state_r == ST_RUN) && q_valid && !(s1_vld_r && s1_cmd_r.last);
  assign start_scan = (state_r == ST_RUN) && s1_vld_r && s1_cmd_r.last;

  assign rd_addr = (state_r == ST_SCAN) ? scan_addr_r : BIN_W'(q_head.bin);

  // count memory write port: sweeps write zero, updates write the new count
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = s1_addr;
    cnt_wdata = s1_new;
    if ((state_r == ST_CLEAR) || (state_r == ST_SCAN)) begin
      cnt_we    = 1'b1;
      cnt_waddr = scan_addr_r;
      cnt_wdata = '0;
    end else if (item_wr) begin
      cnt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fpos_we) begin
      fpos_mem[s1_addr] <= s1_cmd_r.pos;
    end
    fpos_rd_r <= fpos_mem[rd_addr];
  end

  // sweep compare, ties go to the later bin
  assign take = sc_vld_r && (32'(sc_idx_r) <= 32'(max_value)) && (cnt_rd_r >= best_cnt_r);
  assign emit = (state_r == ST_DONE) && !sc_vld_r && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    scan_addr_nxt = scan_addr_r;
    sc_vld_nxt    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        if (scan_addr_r == LAST_BIN) begin
          scan_addr_nxt = '0;
          state_nxt     = ST_RUN;
        end else begin
          scan_addr_nxt = scan_addr_r + BIN_W'(1);
        end
      end
      ST_RUN: begin
        if (start_scan) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        sc_vld_nxt = 1'b1;
        if (scan_addr_r == LAST_BIN) begin
          scan_addr_nxt = '0;
          state_nxt     = ST_DONE;
        end else begin
          scan_addr_nxt = scan_addr_r + BIN_W'(1);
        end
      end
      ST_DONE: begin
        if (emit) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign s1_vld_nxt  = q_pop;
  assign fwd_vld_nxt = item_wr;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scan_addr_r <= '0;
      s1_vld_r    <= 1'b0;
      sc_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      s1_vld_r    <= s1_vld_nxt;
      sc_vld_r    <= sc_vld_nxt;
      fwd_vld_r   <= fwd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r <= q_head;
    end
    sc_idx_r   <= scan_addr_r;
    fwd_addr_r <= s1_addr;
    fwd_data_r <= s1_new;
    if (start_scan) begin
      best_val_r <= '0;
      best_cnt_r <= '0;
      best_pos_r <= '0;
    end else if (take) begin
      best_val_r <= VAL_W'(sc_idx_r);
      best_cnt_r <= cnt_rd_r;
      best_pos_r <= (cnt_rd_r != '0) ? fpos_rd_r : '0;
    end
    if (emit) begin
      out_val_r <= best_val_r;
      out_cnt_r <= best_cnt_r;
      out_pos_r <= best_pos_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mode_value     = out_val_r;
  assign out_ch.mode_count     = out_cnt_r;
  assign out_ch.first_position = out_pos_r;

endmodule

`default_nettype wire

/* tb/window_mode_finder_top_test.sv */
// testbench for window_mode_finder_top: drives sample frames and register settings,
// predicts the mode of each frame and checks every returned result
// depends on wmf_pkg, wmf_if and the window mode finder rtl
`timescale 1ns / 1ps

module window_mode_finder_top_test;
  import wmf_pkg::*;

  localparam int VALUE_BINS = DEF_VALUE_BINS;
  localparam int ITEMS_PER_PHASE = 195;

  typedef struct packed {
    logic [VAL_W-1:0] mode;
    logic [CNT_W-1:0] hits;
    logic [POS_W-1:0] first_pos;
  } mode_result_t;

  // running histogram of the current frame and the modes still owed by the block
  class mode_tally;
    logic [POS_W-1:0]  win_start;
    logic [POS_W-1:0]  win_end;
    logic [MAXV_W-1:0] max_val;
    logic [POS_W-1:0]  next_pos;
    logic [CNT_W-1:0]  hist [VALUE_BINS];
    logic [POS_W-1:0]  first_seen [VALUE_BINS];
    mode_result_t      owed_modes [$];
    int                mismatches;
    int                modes_checked;

    function new();
      win_start = WIN_START_RST;
      win_end = WIN_END_RST;
      max_val = MAX_VALUE_RST;
      next_pos = '0;
      foreach (hist[i]) begin
        hist[i] = '0;
        first_seen[i] = '0;
      end
      mismatches = 0;
      modes_checked = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_WINDOW_START: win_start = data[POS_W-1:0];
        CFG_WINDOW_END:   win_end = data[POS_W-1:0];
        CFG_MAX_VALUE:    max_val = data[MAXV_W-1:0];
        default: ;
      endcase
    endfunction

    // count one accepted sample; a last sample closes the frame with a scan
    function void take_sample(logic [VAL_W-1:0] v, logic last);
      mode_result_t best;
      int b;
      if (next_pos >= win_start && next_pos <= win_end && v <= max_val) begin
        if (hist[v] == '0) first_seen[v] = next_pos;
        if (hist[v] != CNT_MAX) hist[v] = hist[v] + 1'b1;
      end
      next_pos = next_pos + 1'b1;
      if (last) begin
        best = '0;
        // ties go to the larger value, so >= while scanning upward
        for (b = 0; b <= max_val; b++) begin
          if (hist[b] >= best.hits) begin
            best.mode = b[VAL_W-1:0];
            best.hits = hist[b];
            best.first_pos = (hist[b] != '0) ? first_seen[b] : '0;
          end
        end
        owed_modes.push_back(best);
        foreach (hist[i]) hist[i] = '0;
        next_pos = '0;
      end
    endfunction

    function void compare_mode(mode_result_t got);
      mode_result_t want;
      modes_checked++;
      if (owed_modes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mode %0d hits %0d first %0d",
                   got.mode, got.hits, got.first_pos);
        return;
      end
      want = owed_modes.pop_front();
      if (got.mode !== want.mode || got.hits !== want.hits ||
          got.first_pos !== want.first_pos) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: mode exp %0d got %0d, hits exp %0d got %0d, first exp %0d got %0d",
                   modes_checked, want.mode, got.mode, want.hits, got.hits,
                   want.first_pos, got.first_pos);
      end
    endfunction

    function int modes_owed();
      return owed_modes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  wmf_in_if  in_ch ();
  wmf_out_if out_ch ();

  mode_tally tally = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  int samples_sent = 0;
  int frames_sent = 0;
  int settings_used = 0;

  window_mode_finder_top #(
    .VALUE_BINS(VALUE_BINS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: sample the handshake at the falling edge, drive ready at the rising edge
  initial begin : result_sink
    mode_result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.mode = out_ch.mode_value;
        got.hits = out_ch.mode_count;
        got.first_pos = out_ch.first_position;
        tally.compare_mode(got);
      end
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // called at a rising edge; returns at the edge where the request was taken
  task automatic send_sample(input logic [VAL_W-1:0] v, input logic last);
    logic took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_value <= v;
    in_ch.last_sample <= last;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (took !== 1'b1);
    tally.take_sample(v, last);
    samples_sent++;
    if (last) frames_sent++;
  endtask

  // hold off requests until every owed result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tally.modes_owed() != 0);
  endtask

  // new register setting between frames, once the sweep has surely finished
  task automatic reconfigure(input logic [CFG_W-1:0] ws, input logic [CFG_W-1:0] we,
                             input logic [CFG_W-1:0] mv_word);
    drain_results();
    repeat (VALUE_BINS + 16) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WINDOW_START;
    cfg_wdata <= ws;
    @(posedge clk);
    tally.set_reg(CFG_WINDOW_START, ws);
    cfg_index <= CFG_WINDOW_END;
    cfg_wdata <= we;
    @(posedge clk);
    tally.set_reg(CFG_WINDOW_END, we);
    cfg_index <= CFG_MAX_VALUE;
    cfg_wdata <= mv_word;
    @(posedge clk);
    tally.set_reg(CFG_MAX_VALUE, mv_word);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic apply_idle(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_idle_pct = 52;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 52;
      end
      default: begin
        send_idle_pct = 35;
        stall_pct = 35;
      end
    endcase
  endtask

  // mostly counted values, some anywhere in the byte range, some at the edges
  function automatic logic [VAL_W-1:0] pick_value(input logic [MAXV_W-1:0] mv);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return VAL_W'($urandom_range(0, mv));
    if (r < 85) return VAL_W'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      2: return mv;
      default: return mv + 1'b1;
    endcase
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0] ws;
    logic [CFG_W-1:0] we;
    logic [CFG_W-1:0] mvw;
    int ph;
    int sent;
    int len;
    int k;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sample_value <= '0;
    in_ch.last_sample <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WINDOW_START;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames under the reset setting: single sample, tie to larger value
    apply_idle(3);
    send_sample(8'd0, 1'b1);
    send_sample(8'd255, 1'b0);
    send_sample(8'd7, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd7, 1'b1);
    send_sample(8'd3, 1'b0);
    send_sample(8'd3, 1'b0);
    send_sample(8'd9, 1'b1);

    // narrow window, values above the maximum skipped but still numbered
    reconfigure(16'd2, 16'd4, 16'd10);
    send_sample(8'd11, 1'b0);
    send_sample(8'd5, 1'b0);
    send_sample(8'd5, 1'b0);
    send_sample(8'd5, 1'b0);
    send_sample(8'd11, 1'b0);
    send_sample(8'd5, 1'b0);
    send_sample(8'd6, 1'b1);

    // empty window: nothing counted
    reconfigure(16'd5, 16'd4, 16'hff);
    send_sample(8'd1, 1'b0);
    send_sample(8'd2, 1'b1);

    // maximum of zero, and a frame with no counted value
    reconfigure(16'd0, 16'hffff, 16'hff00);
    send_sample(8'd0, 1'b0);
    send_sample(8'd1, 1'b0);
    send_sample(8'd0, 1'b1);
    send_sample(8'd200, 1'b1);

    // window at the top position only
    reconfigure(16'hffff, 16'hffff, 16'hff);
    send_sample(8'd8, 1'b0);
    send_sample(8'd8, 1'b1);

    // random frames over a spread of settings and idle patterns
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          ws = 16'd0; we = 16'hffff; mvw = 16'h00ff;
        end
        1: begin
          ws = 16'd0; we = 16'd0; mvw = 16'd0;
        end
        2: begin
          ws = 16'($urandom_range(0, 10)); we = ws + 16'($urandom_range(0, 30));
          mvw = 16'($urandom_range(1, 7));
        end
        3: begin
          ws = 16'hffff; we = 16'hffff; mvw = 16'($urandom_range(0, 255));
        end
        4: begin
          ws = 16'($urandom_range(10, 40)); we = 16'($urandom_range(0, 9)); mvw = 16'd3;
        end
        5: begin
          ws = 16'($urandom); we = 16'($urandom); mvw = 16'($urandom);
        end
        6: begin
          ws = 16'd0; we = 16'($urandom_range(0, 20)); mvw = {8'hff, 8'hff};
        end
        7: begin
          ws = 16'($urandom_range(0, 5)); we = 16'hffff;
          mvw = {8'($urandom), 8'($urandom_range(2, 15))};
        end
        8: begin
          ws = 16'($urandom); we = 16'hffff; mvw = 16'($urandom);
        end
        default: begin
          ws = 16'd0; we = 16'hffff; mvw = 16'($urandom_range(0, 3));
        end
      endcase
      reconfigure(ws, we, mvw);
      apply_idle(ph % 4);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 90);
        for (k = 0; k < len; k++)
          send_sample(pick_value(mvw[MAXV_W-1:0]), k == len - 1);
        sent += len;
        if ($urandom_range(0, 7) == 0) drain_results();
      end
    end

    // wind down: wait for every owed result, then let the block settle
    drain_results();
    repeat (VALUE_BINS + 32) @(posedge clk);

    $display("ran %0d samples in %0d frames over %0d register settings, %0d results checked",
             samples_sent, frames_sent, settings_used, tally.modes_checked);
    $display("included empty and single-position windows, ties, skipped values and idle mixes");
    if (tally.mismatches == 0 && tally.modes_owed() == 0) begin
      $display("TB_OK");
    end else begin
      $display("mismatches: %0d", tally.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
